[sv/jacobi_poisson_grid_solver_defines.svh]
// Assertion macros for the Jacobi grid solver.
// Included by the top level; no other dependencies.
`ifndef JACOBI_POISSON_GRID_SOLVER_DEFINES_SVH
`define JACOBI_POISSON_GRID_SOLVER_DEFINES_SVH
`ifndef SYNTH
`define JPS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define JPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define JPS_ASSERT_IMP(lbl, ante, cons, msg)
`define JPS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[sv/jps_pkg.sv]
// Shared constants, types and helpers for the Jacobi grid solver.
// No dependencies.
`default_nettype none
package jps_pkg;
    localparam int MAX_COLS    = 64;
    localparam int MAX_ROWS    = 64;
    localparam int VALUE_WIDTH = 32;

    localparam int STORE_DEPTH = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COL_W       = $clog2(MAX_COLS);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int CCNT_W      = $clog2(MAX_COLS + 1);
    localparam int RCNT_W      = $clog2(MAX_ROWS + 1);

    localparam int DATA_W      = 32;
    localparam int DIAG_W      = 31;
    localparam int DIM_W       = 7;
    localparam int IDX_W       = 12;
    localparam int FUNC_W      = 2;
    localparam int ITER_W      = 16;
    localparam int ACC_W       = 64;
    localparam int FRAC_BITS   = 16;
    localparam int NUM_BITS    = 46;
    localparam int DIVIDEND_W  = NUM_BITS + FRAC_BITS;
    localparam int CFG_IDX_W   = 3;

    localparam logic signed [63:0] SAT_HI = (VALUE_WIDTH >= 32) ? 64'sh7FFF_FFFF :
                                            ((64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SOLVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_COLS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIAG = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CY   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ITER = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TOL  = 3'd6;

    typedef struct packed {
        logic                    start;
        logic signed [ACC_W-1:0] num;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] quot;
    } div_rsp_t;

    function automatic logic signed [DATA_W-1:0] sat_value(input logic signed [63:0] v);
        logic signed [63:0] r;
        begin
            r = v;
            if (v > SAT_HI) r = SAT_HI;
            if (v < SAT_LO) r = SAT_LO;
            return r[DATA_W-1:0];
        end
    endfunction
endpackage
`default_nettype wire

[sv/jps_div.sv]
// Bit-serial divider: saturated Q16.16 quotient num*2^16/diag, truncated.
// Depends on jps_pkg.
`default_nettype none
module jps_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [jps_pkg::DIAG_W-1:0]    diag,
    input  wire jps_pkg::div_req_t             req,
    output jps_pkg::div_rsp_t                  rsp
);
    typedef enum logic [1:0] {D_IDLE, D_RUN, D_DONE} dstate_t;
    localparam int CNT_W = $clog2(jps_pkg::DIVIDEND_W);

    dstate_t                              state_reg, state_next;
    logic [CNT_W-1:0]                     cnt_reg, cnt_next;
    logic [jps_pkg::DIVIDEND_W-1:0]       dvd_reg, dvd_next;
    logic [jps_pkg::DIVIDEND_W-1:0]       quo_reg, quo_next;
    logic [jps_pkg::DIAG_W:0]             rem_reg, rem_next;
    logic                                 neg_reg, neg_next;
    logic [jps_pkg::DIAG_W:0]             trial;
    logic [jps_pkg::ACC_W-1:0]            mag;
    logic signed [63:0]                   qval;
    logic                                 over;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        dvd_next   = dvd_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;
        mag        = req.num[jps_pkg::ACC_W-1] ? jps_pkg::ACC_W'(-req.num)
                                               : jps_pkg::ACC_W'(req.num);
        over       = (req.num >= (64'sd1 <<< jps_pkg::NUM_BITS)) ||
                     (req.num <= -(64'sd1 <<< jps_pkg::NUM_BITS));
        trial      = {rem_reg[jps_pkg::DIAG_W-1:0], dvd_reg[jps_pkg::DIVIDEND_W-1]};
        unique case (state_reg)
            D_IDLE: begin
                if (req.start) begin
                    neg_next = req.num[jps_pkg::ACC_W-1];
                    cnt_next = '0;
                    rem_next = '0;
                    dvd_next = {mag[jps_pkg::NUM_BITS-1:0], {jps_pkg::FRAC_BITS{1'b0}}};
                    if (diag == '0 || over) begin
                        quo_next   = (req.num == '0) ? '0 : '1;
                        state_next = D_DONE;
                    end else begin
                        quo_next   = '0;
                        state_next = D_RUN;
                    end
                end
            end
            D_RUN: begin
                dvd_next = {dvd_reg[jps_pkg::DIVIDEND_W-2:0], 1'b0};
                if (trial >= {1'b0, diag}) begin
                    rem_next = trial - {1'b0, diag};
                    quo_next = {quo_reg[jps_pkg::DIVIDEND_W-2:0], 1'b1};
                end else begin
                    rem_next = trial;
                    quo_next = {quo_reg[jps_pkg::DIVIDEND_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(jps_pkg::DIVIDEND_W - 1)) state_next = D_DONE;
            end
            D_DONE: state_next = D_IDLE;
            default: state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
        end else begin
            state_reg <= state_next;
        end
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    assign qval     = neg_reg ? -$signed({2'b00, quo_reg}) : $signed({2'b00, quo_reg});
    assign rsp.done = (state_reg == D_DONE);
    assign rsp.quot = jps_pkg::sat_value(qval);
endmodule
`default_nettype wire

[sv/jacobi_poisson_grid_solver.sv]
// Jacobi five-point-stencil solver: top level, sequencer, stores, shared multiplier.
// Depends on jps_pkg, jps_div and jacobi_poisson_grid_solver_defines.svh.
//
// One transaction in, one out. A point write (func 0) goes straight to the
// result; a point read (func 2) passes a wait and a data state first. A solve
// (func 1) runs on one shared 33x33 multiplier and a bit-serial divider: a
// pass over the N points for the rhs norm, then per sweep an update pass in
// which each point reads its nbrs neighbors and waits on the divider, a
// residual pass, and the iteration check and stop test, where N = cols*rows
// and nbrs (2..4) is a point's neighbor count.
// The input is not ready from acceptance until the result is taken.
`default_nettype none
`include "jacobi_poisson_grid_solver_defines.svh"
module jacobi_poisson_grid_solver (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [79:0]                       s_tdata,   // point_index, rhs_value, guess_value
    input  wire logic [jps_pkg::FUNC_W-1:0]        s_tuser,   // func
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [55:0]                            m_tdata,   // read_value, iterations, converged
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [jps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [jps_pkg::DATA_W-1:0]        cfg_data
);
    typedef enum logic [4:0] {
        S_IDLE, S_RD_WAIT, S_RD_DATA, S_OUT,
        S_N_ADDR, S_N_WAIT, S_N_MUL, S_N_ACC, S_IT_CHECK,
        S_PT_START, S_NB_SEL, S_NB_WAIT, S_NB_MUL, S_NB_ACC, S_PT_END,
        S_DIV_WAIT, S_RS_MUL, S_RS_ACC, S_ADV,
        S_T_MUL0, S_T_MUL1, S_T_ADD, S_T_CMP
    } state_t;

    localparam int AW  = jps_pkg::ADDR_W;
    localparam int CW  = jps_pkg::COL_W;
    localparam int RW  = jps_pkg::ROW_W;
    localparam int CCW = jps_pkg::CCNT_W;
    localparam int RCW = jps_pkg::RCNT_W;
    localparam int DW  = jps_pkg::DATA_W;

    localparam logic [2:0] NB_LEFT   = 3'd0;
    localparam logic [2:0] NB_RIGHT  = 3'd1;
    localparam logic [2:0] NB_UP     = 3'd2;
    localparam logic [2:0] NB_DOWN   = 3'd3;
    localparam logic [2:0] NB_CENTER = 3'd4;

    localparam logic signed [63:0] RES_LIMIT = 64'sd4294967295;

    // configuration
    logic [jps_pkg::DIM_W-1:0]      cfg_cols_reg, cfg_rows_reg;
    logic [jps_pkg::DIAG_W-1:0]     diag_reg;
    logic signed [DW-1:0]           coef_x_reg, coef_y_reg;
    logic [jps_pkg::ITER_W-1:0]     max_iter_reg;
    logic [DW-1:0]                  tol_reg;

    // sequencer
    state_t                         state_reg, state_next;
    logic [AW-1:0]                  k_reg, k_next;
    logic [CW-1:0]                  c_reg, c_next;
    logic [RW-1:0]                  r_reg, r_next;
    logic [CCW-1:0]                 cols_reg, cols_next;
    logic [RCW-1:0]                 rows_reg, rows_next;
    logic [2:0]                     nb_reg, nb_next;
    logic signed [63:0]             acc_reg, acc_next;
    logic [63:0]                    norm_reg, norm_next;
    logic [63:0]                    gamma_reg, gamma_next;
    logic [jps_pkg::ITER_W-1:0]     it_reg, it_next;
    logic                           bank_reg, bank_next;
    logic                           phase_reg, phase_next;
    logic [DW-1:0]                  res_abs_reg, res_abs_next;
    logic [63:0]                    p0_reg, p0_next;
    logic [95:0]                    tnorm_reg, tnorm_next;
    logic [DW-1:0]                  out_read_reg, out_read_next;
    logic [jps_pkg::ITER_W-1:0]     out_iter_reg, out_iter_next;
    logic                           out_conv_reg, out_conv_next;
    logic [AW-1:0]                  rhs_raddr_reg, rhs_raddr_next;
    logic [AW:0]                    sol_raddr_reg, sol_raddr_next;

    // stores
    logic [DW-1:0]                  rhs_mem [jps_pkg::STORE_DEPTH];
    logic [DW-1:0]                  sol_mem [2*jps_pkg::STORE_DEPTH];
    logic signed [DW-1:0]           rhs_q, sol_q;
    logic                           rhs_we, sol_we;
    logic [AW:0]                    sol_waddr;
    logic [DW-1:0]                  sol_wdata;

    // shared multiplier
    logic signed [32:0]             mul_a, mul_b;
    logic signed [65:0]             prod_reg;

    jps_pkg::div_req_t              div_req;
    jps_pkg::div_rsp_t              div_rsp;

    logic [jps_pkg::IDX_W-1:0]      in_idx;
    logic signed [DW-1:0]           in_rhs, in_guess;
    logic [AW-1:0]                  in_addr;
    logic                           in_range;
    logic                           c_last, r_last, pt_last;
    logic                           nb_exists;
    logic [AW-1:0]                  nb_addr;
    logic signed [DW-1:0]           nb_coef;
    logic [2:0]                     nb_final;
    logic signed [63:0]             rhs_ext, res_val;
    logic signed [32:0]             rhs_abs;
    logic [95:0]                    gamma_sh;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            return s[64] ? '1 : s[63:0];
        end
    endfunction

    assign in_idx   = s_tdata[11:0];
    assign in_rhs   = s_tdata[43:12];
    assign in_guess = s_tdata[75:44];
    assign in_addr  = AW'(in_idx);
    assign in_range = int'(in_idx) < jps_pkg::STORE_DEPTH;

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = (state_reg == S_OUT);
    assign m_tdata   = {7'b0, out_conv_reg, out_iter_reg, out_read_reg};
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_cols_reg <= 7'd64;
            cfg_rows_reg <= 7'd64;
            diag_reg     <= 31'd262144;
            coef_x_reg   <= -32'sd65536;
            coef_y_reg   <= -32'sd65536;
            max_iter_reg <= 16'd1000;
            tol_reg      <= 32'd43;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                jps_pkg::REG_COLS: cfg_cols_reg <= cfg_data[jps_pkg::DIM_W-1:0];
                jps_pkg::REG_ROWS: cfg_rows_reg <= cfg_data[jps_pkg::DIM_W-1:0];
                jps_pkg::REG_DIAG: diag_reg     <= cfg_data[jps_pkg::DIAG_W-1:0];
                jps_pkg::REG_CX:   coef_x_reg   <= cfg_data;
                jps_pkg::REG_CY:   coef_y_reg   <= cfg_data;
                jps_pkg::REG_ITER: max_iter_reg <= cfg_data[jps_pkg::ITER_W-1:0];
                jps_pkg::REG_TOL:  tol_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    assign c_last  = (CCW'(c_reg) + CCW'(1)) == cols_reg;
    assign r_last  = (RCW'(r_reg) + RCW'(1)) == rows_reg;
    assign pt_last = c_last && r_last;
    assign nb_final = phase_reg ? NB_CENTER : NB_DOWN;
    assign rhs_ext = {{32{rhs_q[DW-1]}}, rhs_q};
    assign rhs_abs = rhs_q[DW-1] ? -{rhs_q[DW-1], rhs_q} : {rhs_q[DW-1], rhs_q};
    assign res_val = acc_reg - rhs_ext;
    assign gamma_sh = {gamma_reg, 32'b0};

    always_comb begin
        nb_exists = 1'b0;
        nb_addr   = k_reg;
        nb_coef   = coef_x_reg;
        case (nb_reg)
            NB_LEFT: begin
                nb_exists = (c_reg != '0);
                nb_addr   = k_reg - AW'(1);
            end
            NB_RIGHT: begin
                nb_exists = !c_last;
                nb_addr   = k_reg + AW'(1);
            end
            NB_UP: begin
                nb_exists = (r_reg != '0);
                nb_addr   = k_reg - AW'(cols_reg);
                nb_coef   = coef_y_reg;
            end
            NB_DOWN: begin
                nb_exists = !r_last;
                nb_addr   = k_reg + AW'(cols_reg);
                nb_coef   = coef_y_reg;
            end
            NB_CENTER: begin
                nb_exists = phase_reg;
                nb_coef   = $signed({1'b0, diag_reg});
            end
            default: nb_exists = 1'b0;
        endcase
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_N_MUL: begin
                mul_a = rhs_abs;
                mul_b = rhs_abs;
            end
            S_NB_MUL: begin
                mul_a = {nb_coef[DW-1], nb_coef};
                mul_b = {sol_q[DW-1], sol_q};
            end
            S_RS_MUL: begin
                mul_a = {1'b0, res_abs_reg};
                mul_b = {1'b0, res_abs_reg};
            end
            S_T_MUL0: begin
                mul_a = {1'b0, tol_reg};
                mul_b = {1'b0, norm_reg[31:0]};
            end
            S_T_MUL1: begin
                mul_a = {1'b0, tol_reg};
                mul_b = {1'b0, norm_reg[63:32]};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    always_comb begin
        state_next     = state_reg;
        k_next         = k_reg;
        c_next         = c_reg;
        r_next         = r_reg;
        cols_next      = cols_reg;
        rows_next      = rows_reg;
        nb_next        = nb_reg;
        acc_next       = acc_reg;
        norm_next      = norm_reg;
        gamma_next     = gamma_reg;
        it_next        = it_reg;
        bank_next      = bank_reg;
        phase_next     = phase_reg;
        res_abs_next   = res_abs_reg;
        p0_next        = p0_reg;
        tnorm_next     = tnorm_reg;
        out_read_next  = out_read_reg;
        out_iter_next  = out_iter_reg;
        out_conv_next  = out_conv_reg;
        rhs_raddr_next = rhs_raddr_reg;
        sol_raddr_next = sol_raddr_reg;
        rhs_we         = 1'b0;
        sol_we         = 1'b0;
        sol_waddr      = '0;
        sol_wdata      = '0;
        div_req        = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    out_read_next = '0;
                    out_iter_next = '0;
                    out_conv_next = 1'b0;
                    state_next    = S_OUT;
                    unique case (s_tuser)
                        jps_pkg::FUNC_WRITE: begin
                            if (in_range) begin
                                rhs_we    = 1'b1;
                                sol_we    = 1'b1;
                                sol_waddr = {bank_reg, in_addr};
                                sol_wdata = jps_pkg::sat_value({{32{in_guess[DW-1]}}, in_guess});
                            end
                        end
                        jps_pkg::FUNC_SOLVE: begin
                            cols_next = (cfg_cols_reg < 7'd2) ? CCW'(2) :
                                        (int'(cfg_cols_reg) > jps_pkg::MAX_COLS) ?
                                        CCW'(jps_pkg::MAX_COLS) : CCW'(cfg_cols_reg);
                            rows_next = (cfg_rows_reg < 7'd2) ? RCW'(2) :
                                        (int'(cfg_rows_reg) > jps_pkg::MAX_ROWS) ?
                                        RCW'(jps_pkg::MAX_ROWS) : RCW'(cfg_rows_reg);
                            norm_next  = '0;
                            k_next     = '0;
                            c_next     = '0;
                            r_next     = '0;
                            state_next = S_N_ADDR;
                        end
                        jps_pkg::FUNC_READ: begin
                            if (in_range) begin
                                sol_raddr_next = {bank_reg, in_addr};
                                state_next     = S_RD_WAIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RD_WAIT: state_next = S_RD_DATA;
            S_RD_DATA: begin
                out_read_next = sol_q;
                state_next    = S_OUT;
            end
            S_OUT: begin
                if (m_tready) state_next = S_IDLE;
            end
            S_N_ADDR: begin
                rhs_raddr_next = k_reg;
                state_next     = S_N_WAIT;
            end
            S_N_WAIT: state_next = S_N_MUL;
            S_N_MUL:  state_next = S_N_ACC;
            S_N_ACC: begin
                norm_next = sat_add(norm_reg, prod_reg[63:0]);
                if (pt_last) begin
                    it_next    = '0;
                    state_next = S_IT_CHECK;
                end else begin
                    k_next     = k_reg + AW'(1);
                    c_next     = c_last ? '0 : c_reg + CW'(1);
                    r_next     = c_last ? r_reg + RW'(1) : r_reg;
                    state_next = S_N_ADDR;
                end
            end
            S_IT_CHECK: begin
                if (it_reg >= max_iter_reg) begin
                    out_iter_next = it_reg;
                    state_next    = S_OUT;
                end else begin
                    phase_next = 1'b0;
                    gamma_next = '0;
                    k_next     = '0;
                    c_next     = '0;
                    r_next     = '0;
                    state_next = S_PT_START;
                end
            end
            S_PT_START: begin
                acc_next       = '0;
                nb_next        = NB_LEFT;
                rhs_raddr_next = k_reg;
                state_next     = S_NB_SEL;
            end
            S_NB_SEL: begin
                if (nb_exists) begin
                    sol_raddr_next = {bank_reg, nb_addr};
                    state_next     = S_NB_WAIT;
                end else if (nb_reg == nb_final) begin
                    state_next = S_PT_END;
                end else begin
                    nb_next = nb_reg + 3'd1;
                end
            end
            S_NB_WAIT: state_next = S_NB_MUL;
            S_NB_MUL:  state_next = S_NB_ACC;
            S_NB_ACC: begin
                acc_next = acc_reg + ($signed(prod_reg[63:0]) >>> jps_pkg::FRAC_BITS);
                if (nb_reg == nb_final) begin
                    state_next = S_PT_END;
                end else begin
                    nb_next    = nb_reg + 3'd1;
                    state_next = S_NB_SEL;
                end
            end
            S_PT_END: begin
                if (!phase_reg) begin
                    div_req.start = 1'b1;
                    div_req.num   = rhs_ext - acc_reg;
                    state_next    = S_DIV_WAIT;
                end else begin
                    if (res_val > RES_LIMIT)       res_abs_next = '1;
                    else if (res_val < -RES_LIMIT) res_abs_next = '1;
                    else if (res_val < 0)          res_abs_next = DW'(-res_val);
                    else                           res_abs_next = DW'(res_val);
                    state_next = S_RS_MUL;
                end
            end
            S_DIV_WAIT: begin
                if (div_rsp.done) begin
                    sol_we     = 1'b1;
                    sol_waddr  = {!bank_reg, k_reg};
                    sol_wdata  = div_rsp.quot;
                    state_next = S_ADV;
                end
            end
            S_RS_MUL: state_next = S_RS_ACC;
            S_RS_ACC: begin
                gamma_next = sat_add(gamma_reg, prod_reg[63:0]);
                state_next = S_ADV;
            end
            S_ADV: begin
                if (pt_last) begin
                    k_next = '0;
                    c_next = '0;
                    r_next = '0;
                    if (!phase_reg) begin
                        bank_next  = !bank_reg;
                        phase_next = 1'b1;
                        state_next = S_PT_START;
                    end else begin
                        state_next = S_T_MUL0;
                    end
                end else begin
                    k_next     = k_reg + AW'(1);
                    c_next     = c_last ? '0 : c_reg + CW'(1);
                    r_next     = c_last ? r_reg + RW'(1) : r_reg;
                    state_next = S_PT_START;
                end
            end
            S_T_MUL0: state_next = S_T_MUL1;
            S_T_MUL1: begin
                p0_next    = prod_reg[63:0];
                state_next = S_T_ADD;
            end
            S_T_ADD: begin
                tnorm_next = {32'b0, p0_reg} + {prod_reg[63:0], 32'b0};
                state_next = S_T_CMP;
            end
            S_T_CMP: begin
                if (gamma_sh <= tnorm_reg) begin
                    out_iter_next = it_reg;
                    out_conv_next = 1'b1;
                    state_next    = S_OUT;
                end else begin
                    it_next    = it_reg + jps_pkg::ITER_W'(1);
                    state_next = S_IT_CHECK;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            bank_reg  <= 1'b0;
            norm_reg  <= '0;
            phase_reg <= 1'b0;
            nb_reg    <= NB_LEFT;
            it_reg    <= '0;
        end else begin
            state_reg <= state_next;
            bank_reg  <= bank_next;
            norm_reg  <= norm_next;
            phase_reg <= phase_next;
            nb_reg    <= nb_next;
            it_reg    <= it_next;
        end
        k_reg         <= k_next;
        c_reg         <= c_next;
        r_reg         <= r_next;
        cols_reg      <= cols_next;
        rows_reg      <= rows_next;
        acc_reg       <= acc_next;
        gamma_reg     <= gamma_next;
        res_abs_reg   <= res_abs_next;
        p0_reg        <= p0_next;
        tnorm_reg     <= tnorm_next;
        out_read_reg  <= out_read_next;
        out_iter_reg  <= out_iter_next;
        out_conv_reg  <= out_conv_next;
        rhs_raddr_reg <= rhs_raddr_next;
        sol_raddr_reg <= sol_raddr_next;
    end

    always_ff @(posedge aclk) begin
        if (rhs_we) rhs_mem[in_addr] <= in_rhs;
        rhs_q <= rhs_mem[rhs_raddr_reg];
    end

    always_ff @(posedge aclk) begin
        if (sol_we) sol_mem[sol_waddr] <= sol_wdata;
        sol_q <= sol_mem[sol_raddr_reg];
    end

    jps_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .diag    (diag_reg),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    `JPS_ASSERT_IMP(a_ready_excl, s_tready, !m_tvalid, "input ready while result pending")
    `JPS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready after accept")
    `JPS_ASSERT_IMP(a_conv_bound, m_tvalid && out_conv_reg, out_iter_reg < max_iter_reg, "bad count")
    `JPS_ASSERT_IMP(a_div_owner, div_rsp.done, state_reg == S_DIV_WAIT, "divider done while not waiting")
endmodule
`default_nettype wire
